### src/abac_pkg.sv
package abac_pkg;

  localparam int MAX_STEPS_DEF = 512;

  // Shared multiplier operand widths.
  localparam int MUL_A_W = 37;
  localparam int MUL_B_W = 33;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int ACC_W = 50;

  // Configuration register indexes.
  localparam logic [2:0] REG_GAIN_P   = 3'd0;
  localparam logic [2:0] REG_GAIN_I   = 3'd1;
  localparam logic [2:0] REG_GAIN_D   = 3'd2;
  localparam logic [2:0] REG_BIAS     = 3'd3;
  localparam logic [2:0] REG_TARGET   = 3'd4;
  localparam logic [2:0] REG_FLOOR    = 3'd5;
  localparam logic [2:0] REG_RAMP     = 3'd6;
  localparam logic [2:0] REG_DRAG     = 3'd7;

  // Fixed-point constants.
  localparam logic [11:0] G_Q8        = 12'd2511;
  localparam logic [12:0] HALF_STEP   = 13'd3277;
  localparam logic [12:0] FULL_STEP   = 13'd6554;
  localparam logic [10:0] SIXTH_STEP  = 11'd1092;
  localparam logic [17:0] DT_Q24      = 18'd167772;
  localparam logic [6:0]  INV_DT      = 7'd100;
  localparam logic [19:0] AREA_MAX    = 20'hFFFFF;
  localparam logic [19:0] AREA_RESET  = 20'd16384;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

### src/airbrake_apogee_controller.sv
// Channel   Direction  Signals
// -------   ---------  -------------------------------------------------
// in        input      in_valid/in_ready: armed, velocity, altitude
// out       output     out_valid/out_ready: brake_area, predicted_apogee,
//                      control_active, horizon_capped
// cfg       input      cfg_valid/cfg_ready: cfg_index, cfg_data
//
// An inactive sample (not armed, or velocity not positive) is answered in the
// cycle after it is accepted. An active sample runs up to MAX_STEPS RK4 steps
// and then the PID and area update, and the next sample is taken only once it
// is done; the single shared multiplier is used twelve times per step.
// Reset is synchronous and active high; it restores register defaults and
// the controller state. While a transaction waits on out_ready, the block
// holds its result and finishes the next active sample only after it leaves.
module airbrake_apogee_controller #(
  parameter int MAX_STEPS = abac_pkg::MAX_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               armed,
  input  logic signed [23:0] velocity,
  input  logic signed [23:0] altitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [19:0] brake_area,
  output logic signed [31:0] predicted_apogee,
  output logic               control_active,
  output logic               horizon_capped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data
);

  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int SUM_W  = 23 + $clog2(MAX_STEPS);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_COEF  = 5'd1;
  localparam logic [4:0] S_CLAT  = 5'd2;
  localparam logic [4:0] S_A1    = 5'd3;
  localparam logic [4:0] S_A2    = 5'd4;
  localparam logic [4:0] S_A3    = 5'd5;
  localparam logic [4:0] S_A4    = 5'd6;
  localparam logic [4:0] S_A5    = 5'd7;
  localparam logic [4:0] S_UPD   = 5'd8;
  localparam logic [4:0] S_APO   = 5'd9;
  localparam logic [4:0] S_APO2  = 5'd10;
  localparam logic [4:0] S_ERR   = 5'd11;
  localparam logic [4:0] S_EI    = 5'd12;
  localparam logic [4:0] S_ES    = 5'd13;
  localparam logic [4:0] S_D     = 5'd14;
  localparam logic [4:0] S_P     = 5'd15;
  localparam logic [4:0] S_I     = 5'd16;
  localparam logic [4:0] S_DD    = 5'd17;
  localparam logic [4:0] S_AREA  = 5'd18;

  // Configuration registers.
  logic signed [31:0] gain_p, gain_i, gain_d;
  logic signed [20:0] output_bias;
  logic        [22:0] target_apogee;
  logic        [19:0] area_floor;
  logic        [15:0] ramp_step;
  logic        [23:0] drag_factor;

  // Controller state.
  logic        [19:0] area_now;
  logic signed [31:0] last_error;
  logic signed [39:0] error_sum;

  // Sequencer and datapath registers.
  logic [4:0]                 state;
  logic signed [23:0]         alt;
  logic [27:0]                coef;
  logic signed [31:0]         v, vin, kreg, e, d, apogee;
  logic signed [35:0]         ksum;
  logic [1:0]                 kidx;
  logic [STEP_W-1:0]          steps;
  logic [SUM_W-1:0]           sum;
  logic                       capped;
  logic signed [abac_pkg::ACC_W-1:0] acc;

  // Shared multiplier with a registered product.
  logic signed [abac_pkg::MUL_A_W-1:0] mul_a;
  logic signed [abac_pkg::MUL_B_W-1:0] mul_b;
  logic signed [abac_pkg::MUL_P_W-1:0] prod_q;

  logic [27:0]        vabs;
  logic [52:0]        dsum;
  logic signed [31:0] k_now;
  logic signed [31:0] vnext;
  logic signed [32:0] ediff;
  logic signed [39:0] apo_wide;
  logic signed [33:0] err_wide;
  logic signed [40:0] es_wide;
  logic signed [abac_pkg::ACC_W-1:0] shifted;
  logic signed [21:0] area_tmp;
  logic               start_ok;
  logic               load_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign start_ok  = in_valid && in_ready;

  // A result is loaded for an inactive sample at once, or when an update completes.
  assign load_out = (start_ok && !(armed && (velocity > 24'sd0)))
                 || ((state == S_AREA) && (!out_valid || out_ready));

  assign vabs  = vin[31] ? 28'(-vin) : vin[27:0];
  assign dsum  = 53'(prod_q[59:8]) + 53'(abac_pkg::G_Q8);
  assign k_now = (dsum >= 53'h8000_0000) ? 32'sh8000_0000 : -$signed(dsum[31:0]);
  assign vnext = v + 32'(prod_q >>> 16);
  assign ediff = 33'(e) - 33'(last_error);
  assign apo_wide = 40'(alt) + 40'(prod_q >>> 16);
  assign err_wide = 34'(apogee) - $signed({11'd0, target_apogee});
  assign es_wide  = 41'(error_sum) + 41'(prod_q >>> 16);
  assign shifted  = abac_pkg::ACC_W'(prod_q >>> 16);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_COEF: begin
        mul_a = $signed({13'd0, drag_factor});
        mul_b = $signed({13'd0, area_now});
      end
      S_A1: begin
        mul_a = $signed({9'd0, coef});
        mul_b = $signed({5'd0, vabs});
      end
      S_A2: begin
        mul_a = $signed({5'd0, prod_q[55:24]});
        mul_b = $signed({5'd0, vabs});
      end
      S_A4: begin
        if (kidx == 2'd3) begin
          mul_a = 37'(ksum);
          mul_b = $signed({22'd0, abac_pkg::SIXTH_STEP});
        end else begin
          mul_a = 37'(kreg);
          mul_b = (kidx == 2'd2) ? $signed({20'd0, abac_pkg::FULL_STEP})
                                 : $signed({20'd0, abac_pkg::HALF_STEP});
        end
      end
      S_APO: begin
        mul_a = $signed(abac_pkg::MUL_A_W'(sum));
        mul_b = $signed({20'd0, abac_pkg::FULL_STEP});
      end
      S_EI: begin
        mul_a = 37'(e);
        mul_b = $signed({15'd0, abac_pkg::DT_Q24});
      end
      S_ES: begin
        mul_a = 37'(ediff);
        mul_b = $signed({26'd0, abac_pkg::INV_DT});
      end
      S_D: begin
        mul_a = 37'(gain_p);
        mul_b = 33'(e);
      end
      S_P: begin
        mul_a = 37'(gain_i);
        mul_b = 33'($signed(error_sum[39:8]));
      end
      S_I: begin
        mul_a = 37'(gain_d);
        mul_b = 33'(d);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_q <= mul_a * mul_b;
  end

  // The new area: one ramp step toward the output, then floor and ceiling.
  always_comb begin
    area_tmp = $signed({2'b00, area_now});
    if (acc > $signed(abac_pkg::ACC_W'(area_now))) begin
      area_tmp = $signed({2'b00, area_now}) + $signed({6'd0, ramp_step});
    end else if (acc < $signed(abac_pkg::ACC_W'(area_now))) begin
      area_tmp = $signed({2'b00, area_now}) - $signed({6'd0, ramp_step});
    end
    if (area_tmp < $signed({2'b00, area_floor})) begin
      area_tmp = $signed({2'b00, area_floor});
    end
    if (area_tmp > $signed({2'b00, abac_pkg::AREA_MAX})) begin
      area_tmp = $signed({2'b00, abac_pkg::AREA_MAX});
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p        <= 32'sd1678;
      gain_i        <= 32'sd83886;
      gain_d        <= '0;
      output_bias   <= '0;
      target_apogee <= 23'd204800;
      area_floor    <= 20'd16384;
      ramp_step     <= 16'd328;
      drag_factor   <= 24'd216925;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        abac_pkg::REG_GAIN_P: gain_p        <= cfg_data;
        abac_pkg::REG_GAIN_I: gain_i        <= cfg_data;
        abac_pkg::REG_GAIN_D: gain_d        <= cfg_data;
        abac_pkg::REG_BIAS:   output_bias   <= cfg_data[20:0];
        abac_pkg::REG_TARGET: target_apogee <= cfg_data[22:0];
        abac_pkg::REG_FLOOR:  area_floor    <= cfg_data[19:0];
        abac_pkg::REG_RAMP:   ramp_step     <= cfg_data[15:0];
        abac_pkg::REG_DRAG:   drag_factor   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Result valid flag: set when a result is loaded, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer. Each state consumes the product issued by the one before it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      area_now   <= abac_pkg::AREA_RESET;
      last_error <= '0;
      error_sum  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start_ok) begin
            alt    <= altitude;
            v      <= 32'(velocity);
            vin    <= 32'(velocity);
            sum    <= '0;
            steps  <= '0;
            capped <= 1'b0;
            if (armed && (velocity > 24'sd0)) begin
              state <= S_COEF;
            end else begin
              // Inactive samples leave the state alone and answer at once.
              brake_area       <= area_now;
              predicted_apogee <= '0;
              control_active   <= 1'b0;
              horizon_capped   <= 1'b0;
            end
          end
        end
        S_COEF: state <= S_CLAT;
        S_CLAT: begin
          coef  <= prod_q[43:16];
          kidx  <= '0;
          ksum  <= '0;
          state <= S_A1;
        end
        S_A1: state <= S_A2;
        S_A2: state <= S_A3;
        S_A3: begin
          kreg <= k_now;
          if (kidx == 2'd1 || kidx == 2'd2) begin
            ksum <= ksum + (36'(k_now) <<< 1);
          end else begin
            ksum <= ksum + 36'(k_now);
          end
          state <= S_A4;
        end
        S_A4: state <= (kidx == 2'd3) ? S_UPD : S_A5;
        S_A5: begin
          vin   <= vnext;
          kidx  <= kidx + 2'd1;
          state <= S_A1;
        end
        S_UPD: begin
          steps <= steps + 1'b1;
          if (vnext <= 32'sd0) begin
            state <= S_APO;
          end else begin
            sum  <= sum + SUM_W'(vnext);
            v    <= vnext;
            vin  <= vnext;
            kidx <= '0;
            ksum <= '0;
            if (steps + 1'b1 == STEP_W'(MAX_STEPS)) begin
              capped <= 1'b1;
              state  <= S_APO;
            end else begin
              state <= S_A1;
            end
          end
        end
        S_APO: state <= S_APO2;
        S_APO2: begin
          apogee <= abac_pkg::sat32(64'(apo_wide));
          state  <= S_ERR;
        end
        S_ERR: begin
          e     <= abac_pkg::sat32(64'(err_wide));
          state <= S_EI;
        end
        S_EI: state <= S_ES;
        S_ES: begin
          if (es_wide > 41'sh7F_FFFF_FFFF) begin
            error_sum <= 40'sh7F_FFFF_FFFF;
          end else if (es_wide < -41'sh80_0000_0000) begin
            error_sum <= 40'sh80_0000_0000;
          end else begin
            error_sum <= es_wide[39:0];
          end
          state <= S_D;
        end
        S_D: begin
          d          <= abac_pkg::sat32(64'(prod_q));
          last_error <= e;
          state      <= S_P;
        end
        S_P: begin
          acc   <= shifted + abac_pkg::ACC_W'(output_bias);
          state <= S_I;
        end
        S_I: begin
          acc   <= acc + shifted;
          state <= S_DD;
        end
        S_DD: begin
          acc   <= acc + shifted;
          state <= S_AREA;
        end
        S_AREA: begin
          if (!out_valid || out_ready) begin
            area_now         <= area_tmp[19:0];
            brake_area       <= area_tmp[19:0];
            predicted_apogee <= apogee;
            control_active   <= 1'b1;
            horizon_capped   <= capped;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("input accepted while a sample is in progress");
  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> steps <= STEP_W'(MAX_STEPS))
    else $error("step counter passed the horizon");
  a_capped_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && horizon_capped |-> control_active)
    else $error("horizon flag on an inactive result");
  a_area_floor: assert property (@(posedge clk) disable iff (rst)
    state == S_AREA && !out_valid |=> area_now >= $past(area_floor))
    else $error("area left below the floor after an update");
`endif

endmodule

### dv/airbrake_apogee_controller_tb.sv
`timescale 1ns / 100ps

// This testbench checks the airbrake apogee controller end to end. A short table of
// directed samples opens the run, then random samples are sent under several register
// settings, the extremes among them. Every accepted sample goes through a local copy of
// the controller (RK4 apogee prediction, PID and area ramp), and each result transaction
// is compared field by field against the oldest expectation in the queue.
module airbrake_apogee_controller_tb;

  localparam int HORIZON = abac_pkg::MAX_STEPS_DEF;
  // Bound for the whole run: active samples may run the full RK4 step horizon, plus stalls on both sides.
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint S40_MAX = (64'sd1 <<< 39) - 1;
  localparam longint S40_MIN = -(64'sd1 <<< 39);
  localparam int DEFAULT_ROWS = 10;

  typedef struct packed {
    logic               armed;
    logic signed [23:0] vel;
    logic signed [23:0] alt;
  } sample_t;

  typedef struct packed {
    logic        [19:0] area;
    logic signed [31:0] apogee;
    logic               active;
    logic               capped;
  } result_t;

  typedef struct packed {
    sample_t s;
    logic    typed;
    result_t r;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               armed = 1'b0;
  logic signed [23:0] velocity = '0;
  logic signed [23:0] altitude = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic        [19:0] brake_area;
  logic signed [31:0] predicted_apogee;
  logic               control_active;
  logic               horizon_capped;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic        [2:0]  cfg_index = '0;
  logic        [31:0] cfg_data = '0;

  airbrake_apogee_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .armed(armed), .velocity(velocity), .altitude(altitude),
    .out_valid(out_valid), .out_ready(out_ready),
    .brake_area(brake_area), .predicted_apogee(predicted_apogee),
    .control_active(control_active), .horizon_capped(horizon_capped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Local copy of the register file and controller state.
  longint gain_p, gain_i, gain_d, bias, target, floor_area, ramp, drag;
  longint area_q, last_err, err_sum;

  result_t expected_q[$];
  int      errors = 0;
  int      cycles = 0;
  bit      quiet = 1'b0;
  int      out_stall = 0;

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // Acceleration in Q8 m/s^2: gravity plus quadratic drag.
  function automatic longint accel_q8(longint v, longint coef);
    longint a;
    longint drag_term;
    a = v < 0 ? -v : v;
    drag_term = (((coef * a) >>> 24) * a) >>> 8;
    return clamp(-2511 - drag_term, S32_MIN, S32_MAX);
  endfunction

  function automatic longint rk4_velocity(longint v, longint coef);
    longint k1, k2, k3, k4;
    k1 = accel_q8(v, coef);
    k2 = accel_q8(v + ((k1 * 3277) >>> 16), coef);
    k3 = accel_q8(v + ((k2 * 3277) >>> 16), coef);
    k4 = accel_q8(v + ((k3 * 6554) >>> 16), coef);
    return v + (((k1 + 2 * k2 + 2 * k3 + k4) * 1092) >>> 16);
  endfunction

  // Predicts the result of one sample and advances the controller state.
  function automatic result_t control_step(sample_t s);
    result_t r;
    longint  v, coef, sum, apo, e, d, drive;
    int      steps;
    r = '0;
    apo = 0;
    if (s.armed && s.vel > 0) begin
      r.active = 1'b1;
      coef = (drag * area_q) >>> 16;
      v = longint'(s.vel);
      sum = 0;
      steps = 0;
      while (1) begin
        if (steps >= HORIZON) begin
          r.capped = 1'b1;
          break;
        end
        v = rk4_velocity(v, coef);
        steps++;
        if (v <= 0) break;
        sum += v;
      end
      apo = clamp(longint'(s.alt) + ((sum * 6554) >>> 16), S32_MIN, S32_MAX);
      e = clamp(apo - target, S32_MIN, S32_MAX);
      err_sum = clamp(err_sum + ((e * 167772) >>> 16), S40_MIN, S40_MAX);
      d = clamp((e - last_err) * 100, S32_MIN, S32_MAX);
      last_err = e;
      drive = ((gain_p * e) >>> 16) + ((gain_i * (err_sum >>> 8)) >>> 16)
            + ((gain_d * d) >>> 16) + bias;
      if (drive > area_q) begin
        area_q += ramp;
      end else if (drive < area_q) begin
        area_q -= ramp;
      end
      if (area_q < floor_area) area_q = floor_area;
      if (area_q > 1048575) area_q = 1048575;
    end
    r.area = area_q[19:0];
    r.apogee = apo[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  // Result monitor: every accepted result transaction is matched against the queue.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, brake_area", brake_area, 0);
      end else begin
        want = expected_q.pop_front();
        if (brake_area !== want.area)
          report_mismatch("brake_area", brake_area, want.area);
        if (predicted_apogee !== want.apogee)
          report_mismatch("predicted_apogee", predicted_apogee, want.apogee);
        if (control_active !== want.active)
          report_mismatch("control_active", control_active, want.active);
        if (horizon_capped !== want.capped)
          report_mismatch("horizon_capped", horizon_capped, want.capped);
      end
    end
  end

  // Output back-pressure comes in random bursts, and stops in the final phase.
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic hold_off(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Sends one sample and queues its expectation once the transaction is accepted.
  // When typed is set, the expectation comes from the table instead of the predictor.
  task automatic send_sample(sample_t s, logic typed, result_t typed_r);
    result_t r;
    in_valid <= 1'b1;
    armed <= s.armed;
    velocity <= s.vel;
    altitude <= s.alt;
    do @(posedge clk); while (!in_ready);
    r = control_step(s);
    expected_q.push_back(typed ? typed_r : r);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      abac_pkg::REG_GAIN_P: gain_p = longint'($signed(data));
      abac_pkg::REG_GAIN_I: gain_i = longint'($signed(data));
      abac_pkg::REG_GAIN_D: gain_d = longint'($signed(data));
      abac_pkg::REG_BIAS:   bias = longint'($signed(data[20:0]));
      abac_pkg::REG_TARGET: target = longint'(data[22:0]);
      abac_pkg::REG_FLOOR:  floor_area = longint'(data[19:0]);
      abac_pkg::REG_RAMP:   ramp = longint'(data[15:0]);
      default:              drag = longint'(data[23:0]);
    endcase
  endtask

  // Random samples: mostly armed ascents at plausible speeds, with some full-range noise.
  task automatic run_random(int count);
    sample_t s;
    int      pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      s.armed = ($urandom_range(0, 4) != 0);
      s.alt = 24'($urandom);
      if (pick == 0) begin
        s.vel = 24'($urandom);
      end else if (pick == 1) begin
        s.vel = -$signed({1'b0, 23'($urandom)});
      end else begin
        s.vel = 24'($urandom_range(1, 300 * 256));
        if (pick < 5) s.alt = 24'($urandom_range(0, 3000 * 256));
      end
      if (!quiet && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 9));
      send_sample(s, 1'b0, '0);
    end
  endtask

  // Directed samples. The first rows follow reset and are inactive, so their results
  // are plain: the reset area, no prediction. The rows past DEFAULT_ROWS run with drag
  // off, a full-scale ramp step and no floor, so fast ascents hit the step limit.
  plan_row_t plan [0:13];

  initial begin
    plan = '{
      '{'{1'b0, 24'h7FFFFF, 24'h800000}, 1'b1, '{20'd16384, 32'sd0, 1'b0, 1'b0}},
      '{'{1'b1, 24'h000000, 24'h7FFFFF}, 1'b1, '{20'd16384, 32'sd0, 1'b0, 1'b0}},
      '{'{1'b1, 24'h800000, 24'h000000}, 1'b1, '{20'd16384, 32'sd0, 1'b0, 1'b0}},
      '{'{1'b0, 24'hFFFFFF, 24'h7FFFFF}, 1'b1, '{20'd16384, 32'sd0, 1'b0, 1'b0}},
      '{'{1'b1, 24'h000001, 24'h000000}, 1'b0, '0},
      '{'{1'b1, 24'h7FFFFF, 24'h7FFFFF}, 1'b0, '0},
      '{'{1'b1, 24'h003200, 24'h006400}, 1'b0, '0},
      '{'{1'b1, 24'h005000, 24'h01F400}, 1'b0, '0},
      '{'{1'b1, 24'h00C800, 24'h800000}, 1'b0, '0},
      '{'{1'b0, 24'h00C800, 24'h01F400}, 1'b0, '0},
      '{'{1'b1, 24'h7FFFFF, 24'h000000}, 1'b0, '0},
      '{'{1'b1, 24'h025800, 24'h7FFFFF}, 1'b0, '0},
      '{'{1'b1, 24'h000100, 24'h000000}, 1'b0, '0},
      '{'{1'b1, 24'h01F400, 24'h800000}, 1'b0, '0}
    };
  end

  initial begin
    gain_p = 1678; gain_i = 83886; gain_d = 0; bias = 0;
    target = 204800; floor_area = 16384; ramp = 328; drag = 216925;
    area_q = 16384; last_err = 0; err_sum = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DEFAULT_ROWS; i++) begin
      if (i > 4 && $urandom_range(0, 1) == 0) hold_off($urandom_range(1, 9));
      send_sample(plan[i].s, plan[i].typed, plan[i].r);
    end
    wait_idle();

    write_reg(abac_pkg::REG_DRAG, 32'd0);
    write_reg(abac_pkg::REG_RAMP, 32'hFFFF);
    write_reg(abac_pkg::REG_FLOOR, 32'd0);
    for (int i = DEFAULT_ROWS; i < 14; i++) send_sample(plan[i].s, 1'b0, '0);
    run_random(12);
    wait_idle();

    // Extreme gains and bias with the largest target; upper data bits are junk.
    write_reg(abac_pkg::REG_GAIN_P, 32'h7FFFFFFF);
    write_reg(abac_pkg::REG_GAIN_I, 32'h80000000);
    write_reg(abac_pkg::REG_GAIN_D, 32'h7FFFFFFF);
    write_reg(abac_pkg::REG_BIAS, 32'hFFF00000);
    write_reg(abac_pkg::REG_TARGET, 32'hFF7FFFFF);
    write_reg(abac_pkg::REG_DRAG, 32'hFFFFFFFF);
    run_random(18);
    wait_idle();

    write_reg(abac_pkg::REG_GAIN_P, 32'h80000000);
    write_reg(abac_pkg::REG_GAIN_I, 32'h7FFFFFFF);
    write_reg(abac_pkg::REG_GAIN_D, 32'h80000000);
    write_reg(abac_pkg::REG_BIAS, 32'h000FFFFF);
    write_reg(abac_pkg::REG_TARGET, 32'd0);
    write_reg(abac_pkg::REG_FLOOR, 32'hFFFFF);
    write_reg(abac_pkg::REG_RAMP, 32'd0);
    run_random(14);
    wait_idle();

    // Random settings, some of them limited in range; the floor drops so the area can ramp again.
    write_reg(abac_pkg::REG_GAIN_P, $urandom);
    write_reg(abac_pkg::REG_GAIN_I, $urandom);
    write_reg(abac_pkg::REG_GAIN_D, $urandom_range(0, 1 << 20));
    write_reg(abac_pkg::REG_BIAS, $urandom);
    write_reg(abac_pkg::REG_TARGET, $urandom);
    write_reg(abac_pkg::REG_FLOOR, $urandom_range(0, 1 << 16));
    write_reg(abac_pkg::REG_RAMP, $urandom);
    write_reg(abac_pkg::REG_DRAG, $urandom_range(0, 1 << 19));
    run_random(18);
    wait_idle();

    // Last phase restores the defaults and runs without idling on either side.
    write_reg(abac_pkg::REG_GAIN_P, 32'd1678);
    write_reg(abac_pkg::REG_GAIN_I, 32'd83886);
    write_reg(abac_pkg::REG_GAIN_D, 32'd0);
    write_reg(abac_pkg::REG_BIAS, 32'd0);
    write_reg(abac_pkg::REG_TARGET, 32'd204800);
    write_reg(abac_pkg::REG_FLOOR, 32'd16384);
    write_reg(abac_pkg::REG_RAMP, 32'd328);
    write_reg(abac_pkg::REG_DRAG, 32'd216925);
    quiet = 1'b1;
    run_random(16);
    wait_idle();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
